@@ src/kbt_pkg.sv @@
// Shared constants and types for the keyed block transposition.
// No dependencies; every other file of the block imports this package.
package kbt_pkg;

	localparam int KEY_MAX = 12;
	localparam int CODE_W = 5;
	localparam int LEN_W = 4;
	localparam int IDX_W = $clog2(KEY_MAX);
	localparam int KEY_W = KEY_MAX * CODE_W;
	localparam int APB_AW = 4;
	localparam int APB_DW = 64;

	localparam logic [CODE_W-1:0] PAD_CODE = 5'd30;

	// register index, taken from paddr[APB_AW-1] (8-byte stride)
	localparam logic REG_KEY_LETTERS = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef len_t [KEY_MAX-1:0] rank_tab_t;

	typedef struct packed {
		code_t [KEY_MAX-1:0] letters;
		len_t fill;
	} block_t;

endpackage

@@ src/kbt_cfg.sv @@
// Configuration registers (APB) and the per-column rank table derived from the key.
// Depends on kbt_pkg.
module kbt_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [kbt_pkg::APB_AW-1:0] paddr,
	input logic [kbt_pkg::APB_DW-1:0] pwdata,
	output logic [kbt_pkg::APB_DW-1:0] prdata,
	output logic pready,
	output kbt_pkg::len_t eff_len,
	output kbt_pkg::rank_tab_t rank_tab
);
	import kbt_pkg::*;

	logic [KEY_W-1:0] key_q;
	len_t len_q;
	logic wr_en;
	code_t [KEY_MAX-1:0] key;
	logic [KEY_MAX-1:0] below [KEY_MAX];
	rank_tab_t rank_d;
	rank_tab_t rank_q;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			len_q <= LEN_W'(1);
		end else if (wr_en) begin
			unique case (paddr[APB_AW-1])
				REG_KEY_LETTERS: key_q <= pwdata[KEY_W-1:0];
				REG_KEY_LENGTH:  len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[APB_AW-1])
			REG_KEY_LETTERS: prdata = APB_DW'(key_q);
			REG_KEY_LENGTH:  prdata = APB_DW'(len_q);
			default:         prdata = '0;
		endcase
	end

	// zero acts as one, anything above KEY_MAX is clamped
	always_comb begin
		if (len_q == '0)
			eff_len = LEN_W'(1);
		else if (len_q > LEN_W'(KEY_MAX))
			eff_len = LEN_W'(KEY_MAX);
		else
			eff_len = len_q;
	end

	// rank of column j: key letters below it, equal letters to its left count too
	always_comb begin
		for (int j = 0; j < KEY_MAX; j++) begin
			key[j] = key_q[j*CODE_W +: CODE_W];
		end
		for (int j = 0; j < KEY_MAX; j++) begin
			for (int i = 0; i < KEY_MAX; i++) begin
				below[j][i] = (LEN_W'(i) < eff_len) &&
					((key[i] < key[j]) || ((key[i] == key[j]) && (i < j)));
			end
			rank_d[j] = LEN_W'($countones(below[j]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rank_q <= '0;
		else
			rank_q <= rank_d;
	end

	assign rank_tab = rank_q;

endmodule

@@ src/kbt_front.sv @@
// Front end: accepts letters, gathers a block and hands finished blocks to the queue.
// Depends on kbt_pkg.
module kbt_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input kbt_pkg::code_t letter_code,
	input logic message_end,
	input kbt_pkg::len_t eff_len,
	input logic fifo_full,
	output logic push,
	output kbt_pkg::block_t push_blk
);
	import kbt_pkg::*;

	code_t [KEY_MAX-1:0] gather_q;
	len_t fill_q;
	code_t [KEY_MAX-1:0] gather_nxt;
	len_t fill_nxt;
	logic accept;
	logic emit;

	assign in_stall = fifo_full;
	assign accept = in_valid & ~fifo_full;

	always_comb begin
		gather_nxt = gather_q;
		fill_nxt = fill_q;
		// letters past KEY_MAX are dropped, count saturates
		if (fill_q < LEN_W'(KEY_MAX)) begin
			gather_nxt[fill_q[IDX_W-1:0]] = letter_code;
			fill_nxt = fill_q + LEN_W'(1);
		end
		emit = message_end || (fill_nxt >= eff_len);
	end

	assign push = accept & emit;
	assign push_blk = '{letters: gather_nxt, fill: fill_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (accept)
			fill_q <= emit ? '0 : fill_nxt;
	end

	always_ff @(posedge clk) begin
		if (accept)
			gather_q <= gather_nxt;
	end

endmodule

@@ src/kbt_fifo.sv @@
// Two-entry block queue between the front end and the emit unit.
// Depends on kbt_pkg.
module kbt_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input kbt_pkg::block_t push_blk,
	input logic pop,
	output logic head_valid,
	output kbt_pkg::block_t head_blk,
	output logic full
);
	import kbt_pkg::*;

	block_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign head_valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign head_blk = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_blk;
	end

endmodule

@@ src/kbt_back.sv @@
// Emit unit: walks output positions of the head block and drives the output register.
// Depends on kbt_pkg.
module kbt_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input kbt_pkg::block_t head_blk,
	input kbt_pkg::len_t eff_len,
	input kbt_pkg::rank_tab_t rank_tab,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output kbt_pkg::code_t cipher_code,
	output logic block_last
);
	import kbt_pkg::*;

	len_t pos_q;
	logic out_valid_q;
	code_t cipher_code_q;
	logic block_last_q;
	logic advance;
	logic load;
	logic at_end;
	logic [KEY_MAX-1:0] hit;
	code_t sel_code;

	assign advance = ~out_valid_q | ~out_stall;
	assign load = head_valid & advance;
	assign at_end = (pos_q == eff_len - LEN_W'(1));
	assign pop = load & at_end;

	// column whose rank equals the current output position; unfilled columns pad
	always_comb begin
		sel_code = '0;
		for (int j = 0; j < KEY_MAX; j++) begin
			hit[j] = (LEN_W'(j) < eff_len) && (rank_tab[j] == pos_q);
			if (hit[j])
				sel_code = sel_code |
					((LEN_W'(j) < head_blk.fill) ? head_blk.letters[j] : PAD_CODE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (advance)
				out_valid_q <= head_valid;
			if (load)
				pos_q <= at_end ? '0 : pos_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cipher_code_q <= sel_code;
			block_last_q <= at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign cipher_code = cipher_code_q;
	assign block_last = block_last_q;

`ifndef SYNTHESIS
	a_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (pos_q == '0))
		else $error("output position not at start with no block queued");

	a_one_column: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> $onehot(hit))
		else $error("output position does not map to exactly one column");

	a_out_from_block: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(head_valid))
		else $error("result raised without a queued block");
`endif

endmodule

@@ src/keyed_block_transposition.sv @@
// Top level of the keyed block transposition: APB registers, front end, queue, emit unit.
// Depends on kbt_pkg, kbt_cfg, kbt_front, kbt_fifo, kbt_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | in_valid / in_stall  | letter_code, message_end
//  output   | out_valid / out_stall| cipher_code, block_last
//  config   | APB psel/penable     | paddr, pwdata / prdata
//
// One letter is taken per cycle while the two-block queue has room; a block of
// eff_len results leaves the emit unit at one result per cycle while out_stall is low.
// A closing letter puts its block in the queue; results leave via the output register.
// The rank table follows a key write through key_q and then the rank_q register.
// Reset clears counters, handshake, key, length and rank table; no clearing pass is needed.
// in_stall is high only while the queue holds two blocks; out_stall holds the output register.
module keyed_block_transposition (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [kbt_pkg::APB_AW-1:0] paddr,
	input logic [kbt_pkg::APB_DW-1:0] pwdata,
	output logic [kbt_pkg::APB_DW-1:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [kbt_pkg::CODE_W-1:0] letter_code,
	input logic message_end,
	output logic out_valid,
	input logic out_stall,
	output logic [kbt_pkg::CODE_W-1:0] cipher_code,
	output logic block_last
);
	import kbt_pkg::*;

	len_t eff_len;
	rank_tab_t rank_tab;
	logic push;
	block_t push_blk;
	logic pop;
	logic head_valid;
	block_t head_blk;
	logic fifo_full;

	kbt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.eff_len  (eff_len),
		.rank_tab (rank_tab)
	);

	kbt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.letter_code (letter_code),
		.message_end (message_end),
		.eff_len     (eff_len),
		.fifo_full   (fifo_full),
		.push        (push),
		.push_blk    (push_blk)
	);

	kbt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_blk   (push_blk),
		.pop        (pop),
		.head_valid (head_valid),
		.head_blk   (head_blk),
		.full       (fifo_full)
	);

	kbt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_blk    (head_blk),
		.eff_len     (eff_len),
		.rank_tab    (rank_tab),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cipher_code (cipher_code),
		.block_last  (block_last)
	);

endmodule

@@ sim/tb_keyed_block_transposition.sv @@
// Self-checking testbench for keyed_block_transposition: directed table, then random phases.
// Depends on kbt_pkg and the block's RTL; results are checked against a behavioral predictor.
`timescale 1ns / 100ps

module tb_keyed_block_transposition;
	import kbt_pkg::*;

	typedef struct packed {
		code_t code;
		logic last;
	} result_t;

	typedef enum logic {ROW_LETTER, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic sel;
		logic [APB_DW-1:0] value;
		code_t letter;
		logic last;
		logic typed;
		code_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [CODE_W-1:0] letter_code;
	logic message_end;
	logic out_valid;
	logic out_stall;
	logic [CODE_W-1:0] cipher_code;
	logic block_last;

	// predictor state
	logic [KEY_W-1:0] pred_key;
	len_t pred_len;
	code_t pred_store[KEY_MAX];
	int pred_fill;
	result_t emitted[$];

	result_t expected_out[$];
	stim_row_t directed_rows[$];
	int errors = 0;
	int burst_left = 0;

	keyed_block_transposition uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.letter_code(letter_code),
		.message_end(message_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cipher_code(cipher_code),
		.block_last(block_last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int block_len();
		int n;
		n = pred_len;
		if (n == 0)
			n = 1;
		if (n > KEY_MAX)
			n = KEY_MAX;
		return n;
	endfunction

	function automatic code_t key_code(int j);
		return pred_key[CODE_W*j +: CODE_W];
	endfunction

	// Gather one letter; on a full block or message end, fill emitted[] with the
	// transposed block. Equal key letters rank left to right.
	function automatic void transpose_step(code_t c, logic e);
		int n;
		int r;
		int i;
		int j;
		code_t placed[KEY_MAX];
		result_t res;
		n = block_len();
		emitted.delete();
		if (pred_fill < KEY_MAX) begin
			pred_store[pred_fill] = c;
			pred_fill++;
		end
		if (pred_fill < n && !e)
			return;
		for (j = 0; j < n; j++)
			placed[j] = PAD_CODE;
		for (j = 0; j < n; j++) begin
			r = 0;
			for (i = 0; i < n; i++)
				if (key_code(i) < key_code(j) || (key_code(i) == key_code(j) && i < j))
					r++;
			placed[r] = (j < pred_fill) ? pred_store[j] : PAD_CODE;
		end
		for (j = 0; j < n; j++) begin
			res.code = placed[j];
			res.last = (j == n - 1);
			emitted.insert(emitted.size(), res);
		end
		pred_fill = 0;
	endfunction

	function automatic logic [APB_DW-1:0] random_key(int style);
		logic [APB_DW-1:0] k;
		code_t same;
		int j;
		k = APB_DW'($urandom) << 32 | APB_DW'($urandom);
		same = code_t'($urandom_range(0, 31));
		for (j = 0; j < KEY_MAX; j++) begin
			case (style)
				0: k[CODE_W*j +: CODE_W] = code_t'($urandom_range(0, 31));
				1: k[CODE_W*j +: CODE_W] = code_t'($urandom_range(0, 3));  // many ties
				2: k[CODE_W*j +: CODE_W] = code_t'(KEY_MAX - 1 - j);
				default: k[CODE_W*j +: CODE_W] = same;
			endcase
		end
		return k;
	endfunction

	function automatic stim_row_t letter_row(code_t c, logic e, logic typed, code_t want);
		stim_row_t row;
		row = '0;
		row.kind = ROW_LETTER;
		row.letter = c;
		row.last = e;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic stim_row_t write_row(logic sel, logic [APB_DW-1:0] value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.sel = sel;
		row.value = value;
		return row;
	endfunction

	function automatic void add_row(stim_row_t row);
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// Hold off the sender until every expected result is out, plus settle time
	// for a block that is still working on a partial fill.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic sel, logic [APB_DW-1:0] value);
		wait_drained();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {sel, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_KEY_LETTERS)
			pred_key = value[KEY_W-1:0];
		else
			pred_len = value[LEN_W-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		// rank table follows a key write through key_q, then rank_q
		repeat (2) @(posedge clk);
	endtask

	task automatic push_letter(code_t c, logic e, logic typed, code_t want);
		int gap;
		result_t res;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		letter_code = c;
		message_end = e;
		do @(posedge clk); while (in_stall);
		transpose_step(c, e);
		if (typed) begin
			res.code = want;
			res.last = 1'b1;
			expected_out.insert(expected_out.size(), res);
		end else begin
			foreach (emitted[k])
				expected_out.insert(expected_out.size(), emitted[k]);
		end
	endtask

	// receiver stall pattern, independent of the sender
	initial begin
		int mode;
		int span;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 40);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 99) < 30);
					2: out_stall = ($urandom_range(0, 99) < 75);
					default: out_stall = ~out_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_out.size() == 0) begin
				$error("unexpected transfer: cipher_code %0d block_last %0b",
					cipher_code, block_last);
				errors++;
			end else begin
				want = expected_out.pop_front();
				if (cipher_code !== want.code) begin
					$error("cipher_code: expected %0d, got %0d", want.code, cipher_code);
					errors++;
				end
				if (block_last !== want.last) begin
					$error("block_last: expected %0b, got %0b", want.last, block_last);
					errors++;
				end
			end
		end
	end

	initial begin
		code_t c;
		logic e;
		logic [APB_DW-1:0] len_val;
		int total;
		int phase;
		int span;
		stim_row_t row;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		letter_code = '0;
		message_end = 1'b0;

		pred_key = '0;
		pred_len = len_t'(1);
		pred_fill = 0;
		foreach (pred_store[k])
			pred_store[k] = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset: key length 1, each letter comes back as a one-letter block
		add_row(letter_row(5'd0, 1'b0, 1'b1, 5'd0));
		add_row(letter_row(5'd31, 1'b0, 1'b1, 5'd31));
		add_row(letter_row(5'd21, 1'b0, 1'b1, 5'd21));
		add_row(letter_row(5'd10, 1'b1, 1'b1, 5'd10));
		add_row(letter_row(5'd30, 1'b0, 1'b1, 5'd30));
		// zero length behaves as one
		add_row(write_row(REG_KEY_LENGTH, 64'd0));
		add_row(letter_row(5'd5, 1'b1, 1'b1, 5'd5));
		// three-letter key, then a short block padded at message end
		add_row(write_row(REG_KEY_LETTERS, 64'({5'd1, 5'd0, 5'd2})));
		add_row(write_row(REG_KEY_LENGTH, 64'd3));
		add_row(letter_row(5'd7, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd8, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd9, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd4, 1'b1, 1'b0, 5'd0));
		// tied key letters and key codes 30/31
		add_row(write_row(REG_KEY_LETTERS,
			64'({5'd0, 5'd5, 5'd5, 5'd30, 5'd31})));
		add_row(write_row(REG_KEY_LENGTH, 64'd5));
		add_row(letter_row(5'd16, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd17, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd18, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd19, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd20, 1'b0, 1'b0, 5'd0));
		// all-ones key, length above the maximum clamps to KEY_MAX
		add_row(write_row(REG_KEY_LETTERS, 64'h0FFF_FFFF_FFFF_FFFF));
		add_row(write_row(REG_KEY_LENGTH, 64'd15));
		add_row(letter_row(5'd1, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd2, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd3, 1'b1, 1'b0, 5'd0));
		// shrink the key under a partial block: only the first letters survive
		add_row(write_row(REG_KEY_LENGTH, 64'd6));
		add_row(letter_row(5'd11, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd12, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd13, 1'b0, 1'b0, 5'd0));
		add_row(letter_row(5'd14, 1'b0, 1'b0, 5'd0));
		add_row(write_row(REG_KEY_LENGTH, 64'd2));
		add_row(letter_row(5'd15, 1'b0, 1'b0, 5'd0));

		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.kind == ROW_WRITE)
				reg_write(row.sel, row.value);
			else
				push_letter(row.letter, row.last, row.typed, row.want);
		end

		total = 0;
		phase = 0;
		while (total < 230) begin
			case (phase % 7)
				0: len_val = 64'd12;
				1: len_val = 64'd1;
				2: len_val = 64'd0;
				3: len_val = 64'd15;
				4: len_val = 64'd13;
				default: len_val = 64'($urandom_range(2, 11));
			endcase
			reg_write(REG_KEY_LETTERS, random_key(phase % 4));
			reg_write(REG_KEY_LENGTH, len_val);
			span = $urandom_range(20, 40);
			if (span > 230 - total)
				span = 230 - total;
			repeat (span) begin
				c = ($urandom_range(0, 15) == 0) ? code_t'($urandom_range(30, 31))
					: code_t'($urandom_range(0, 29));
				e = ($urandom_range(0, 11) == 0);
				push_letter(c, e, 1'b0, '0);
				total++;
				if (total == 120)
					wait_drained();
			end
			phase++;
		end

		wait_drained();
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
